// File: rtl/core/rsi_pkg.sv
// Shared types and constants for the render snapshot interpolator.
// Used by rsi_ctrl, rsi_datapath and render_snapshot_interpolator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rsi_pkg;

    // Field widths fixed by the item format
    localparam int unsigned GEN_W    = 32;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned TIME_W   = 63;
    localparam int unsigned IVL_W    = 32;
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned ORDER_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ALPHA_W  = 17;
    localparam int unsigned MAX_CHANNELS = 4;

    // Fraction bits of alpha, one per divider step
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [ALPHA_W-1:0] Q16_ONE     = 17'h10000;
    localparam logic [ALPHA_W-1:0] BLEND_ROUND = 17'h08000;

    // Opcodes
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_NEW_GEN   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ADVANCED  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_HIST_RST  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_STALE     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 3'd4;
    localparam logic [STATUS_W-1:0] STATUS_FRAME     = 3'd5;

    typedef logic [MAX_CHANNELS-1:0][COLOR_W-1:0] color_vec_t;

    // Controller to datapath
    typedef struct packed {
        logic load_input;
        logic offer_commit;
        logic calc_gap;
        logic calc_diff;
        logic decide;
        logic div_step;
        logic mult;
        logic finish_load;
    } rsi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip_div;
        logic out_free;
    } rsi_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/render_snapshot_interpolator.sv
// Channel   | Handshake          | Carries
// s_ (in)   | s_valid / s_ready  | offer snapshot or prepare frame item
// m_ (out)  | m_valid / m_ready  | one result item per input item
//
// An offer item passes through S_OFFER and S_FINISH after acceptance. A prepare
// item passes through S_GAP, S_DIFF and S_DECIDE, then S_DIVIDE when the blend
// factor needs the divider, then S_MULT and S_FINISH. The next item is taken only
// once the controller is back in S_IDLE.
// The alpha divider gives one quotient bit per cycle over 63-bit operands.
// Reset is synchronous, active low, and empties the snapshot store.
// One item is in work at a time; a result held in the output register stalls
// only the next item's final step while m_ready is low.
// Depends on rsi_pkg, rsi_ctrl and rsi_datapath.
`timescale 1ns / 1ps
`default_nettype none

module render_snapshot_interpolator import rsi_pkg::*; #(
    parameter int unsigned COLOR_CHANNELS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_opcode,
    input  wire logic [GEN_W-1:0]   s_generation,
    input  wire logic [TICK_W-1:0]  s_tick,
    input  wire logic [TIME_W-1:0]  s_time_stamp,
    input  wire logic [IVL_W-1:0]   s_fixed_interval,
    input  wire logic [COLOR_W-1:0] s_color_red,
    input  wire logic [COLOR_W-1:0] s_color_green,
    input  wire logic [COLOR_W-1:0] s_color_blue,
    input  wire logic [COLOR_W-1:0] s_color_alpha,
    input  wire logic [ORDER_W-1:0] s_focus_generation,
    input  wire logic [ORDER_W-1:0] s_input_sequence,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic                    m_snapshot_valid,
    output logic [ALPHA_W-1:0]      m_blend_factor,
    output logic [COLOR_W-1:0]      m_out_red,
    output logic [COLOR_W-1:0]      m_out_green,
    output logic [COLOR_W-1:0]      m_out_blue,
    output logic [COLOR_W-1:0]      m_out_alpha_channel,
    output logic [ORDER_W-1:0]      m_out_focus_generation,
    output logic [ORDER_W-1:0]      m_out_input_sequence
);

    rsi_cmd_t   cmd;
    rsi_stat_t  stat;
    color_vec_t in_colors;
    color_vec_t out_colors;

    assign in_colors = {s_color_alpha, s_color_blue, s_color_green, s_color_red};

    rsi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rsi_datapath #(
        .COLOR_CHANNELS (COLOR_CHANNELS)
    ) u_datapath (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .stat                (stat),
        .in_opcode           (s_opcode),
        .in_generation       (s_generation),
        .in_tick             (s_tick),
        .in_time_stamp       (s_time_stamp),
        .in_fixed_interval   (s_fixed_interval),
        .in_colors           (in_colors),
        .in_focus_generation (s_focus_generation),
        .in_input_sequence   (s_input_sequence),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_status            (m_status),
        .m_snapshot_valid    (m_snapshot_valid),
        .m_blend_factor      (m_blend_factor),
        .m_colors            (out_colors),
        .m_focus_generation  (m_out_focus_generation),
        .m_input_sequence    (m_out_input_sequence)
    );

    assign m_out_red           = out_colors[0];
    assign m_out_green         = out_colors[1];
    assign m_out_blue          = out_colors[2];
    assign m_out_alpha_channel = out_colors[3];

endmodule

`default_nettype wire

// File: rtl/core/rsi_ctrl.sv
// Sequencing state machine of the render snapshot interpolator.
// Depends on rsi_pkg; drives rsi_datapath through rsi_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module rsi_ctrl import rsi_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_opcode,
    output logic           s_ready,
    input  wire rsi_stat_t stat,
    output rsi_cmd_t       cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_OFFER  = 8'b0000_0010,
        S_GAP    = 8'b0000_0100,
        S_DIFF   = 8'b0000_1000,
        S_DECIDE = 8'b0001_0000,
        S_DIVIDE = 8'b0010_0000,
        S_MULT   = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_input = 1'b1;
                    state_next = (s_opcode == OP_FRAME) ? S_GAP : S_OFFER;
                end
            end
            S_OFFER: begin
                cmd.offer_commit = 1'b1;
                state_next = S_FINISH;
            end
            S_GAP: begin
                cmd.calc_gap = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.calc_diff = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                cnt_next   = '0;
                state_next = stat.skip_div ? S_MULT : S_DIVIDE;
            end
            S_DIVIDE: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = S_MULT;
                end
            end
            S_MULT: begin
                cmd.mult = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register can take the item
                if (stat.out_free) begin
                    cmd.finish_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/rsi_datapath.sv
// Snapshot state, alpha divider, color blend and output register.
// Depends on rsi_pkg; commanded by rsi_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module rsi_datapath import rsi_pkg::*; #(
    parameter int unsigned COLOR_CHANNELS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rsi_cmd_t           cmd,
    output rsi_stat_t               stat,
    input  wire logic               in_opcode,
    input  wire logic [GEN_W-1:0]   in_generation,
    input  wire logic [TICK_W-1:0]  in_tick,
    input  wire logic [TIME_W-1:0]  in_time_stamp,
    input  wire logic [IVL_W-1:0]   in_fixed_interval,
    input  wire color_vec_t         in_colors,
    input  wire logic [ORDER_W-1:0] in_focus_generation,
    input  wire logic [ORDER_W-1:0] in_input_sequence,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic [STATUS_W-1:0]     m_status,
    output logic                    m_snapshot_valid,
    output logic [ALPHA_W-1:0]      m_blend_factor,
    output color_vec_t              m_colors,
    output logic [ORDER_W-1:0]      m_focus_generation,
    output logic [ORDER_W-1:0]      m_input_sequence
);

    localparam int unsigned PROD_W = COLOR_W + ALPHA_W;

    // Latched item
    logic               frame_reg;
    logic [GEN_W-1:0]   in_gen_reg;
    logic [TICK_W-1:0]  in_tick_reg;
    logic [TIME_W-1:0]  in_time_reg;
    logic [IVL_W-1:0]   in_ivl_reg;
    logic [COLOR_W-1:0] in_color_reg [COLOR_CHANNELS];
    logic [ORDER_W-1:0] in_focus_reg;
    logic [ORDER_W-1:0] in_seq_reg;

    // Snapshot state
    logic               have_cur_reg, have_cur_next;
    logic               have_prev_reg, have_prev_next;
    logic [GEN_W-1:0]   cur_gen_reg;
    logic [TICK_W-1:0]  cur_tick_reg;
    logic [TIME_W-1:0]  cur_time_reg;
    logic [IVL_W-1:0]   cur_ivl_reg;
    logic [COLOR_W-1:0] cur_color_reg [COLOR_CHANNELS];
    logic [ORDER_W-1:0] cur_focus_reg;
    logic [ORDER_W-1:0] cur_seq_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic [COLOR_W-1:0] prev_color_reg [COLOR_CHANNELS];

    // Offer decision
    logic [STATUS_W-1:0] offer_status;
    logic                take_item;
    logic                shift_prev;
    logic [STATUS_W-1:0] status_reg;

    // Alpha computation
    logic [TIME_W-1:0]  gap_reg;
    logic [TIME_W:0]    base_reg;
    logic               hist_ok_reg;
    logic [TIME_W:0]    e_reg;
    logic               le_reg;
    logic [TIME_W-1:0]  rem_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic               ge_gap;
    logic [TIME_W:0]    rem_shl;
    logic               q_bit;
    logic [TIME_W:0]    rem_sub;

    // Blend products
    logic [PROD_W-1:0]  prod_prev_reg [COLOR_CHANNELS];
    logic [PROD_W-1:0]  prod_cur_reg  [COLOR_CHANNELS];
    logic [ALPHA_W-1:0] alpha_inv;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic               out_snap_reg;
    logic [ALPHA_W-1:0] out_alpha_reg;
    color_vec_t         out_color_reg, out_color_next;
    logic [ORDER_W-1:0] out_focus_reg, out_focus_next;
    logic [ORDER_W-1:0] out_seq_reg, out_seq_next;
    logic               pick_given;

    // ---------------- item latch ----------------
    always_ff @(posedge aclk) begin
        if (cmd.load_input) begin
            frame_reg    <= in_opcode;
            in_gen_reg   <= in_generation;
            in_tick_reg  <= in_tick;
            in_time_reg  <= in_time_stamp;
            in_ivl_reg   <= in_fixed_interval;
            in_focus_reg <= in_focus_generation;
            in_seq_reg   <= in_input_sequence;
        end
    end

    // ---------------- offer decision ----------------
    always_comb begin
        take_item  = 1'b0;
        shift_prev = 1'b0;
        if (in_ivl_reg == '0) begin
            offer_status = STATUS_REJECTED;
        end else if (!have_cur_reg || in_gen_reg > cur_gen_reg) begin
            offer_status = STATUS_NEW_GEN;
            take_item    = 1'b1;
        end else if (in_gen_reg < cur_gen_reg || in_tick_reg <= cur_tick_reg) begin
            offer_status = STATUS_STALE;
        end else if (in_time_reg <= cur_time_reg || in_ivl_reg != cur_ivl_reg) begin
            offer_status = STATUS_HIST_RST;
            take_item    = 1'b1;
        end else begin
            offer_status = STATUS_ADVANCED;
            take_item    = 1'b1;
            shift_prev   = 1'b1;
        end
    end

    always_comb begin
        have_cur_next  = have_cur_reg;
        have_prev_next = have_prev_reg;
        if (cmd.offer_commit && take_item) begin
            have_cur_next  = 1'b1;
            have_prev_next = shift_prev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_cur_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
        end else begin
            have_cur_reg  <= have_cur_next;
            have_prev_reg <= have_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.offer_commit) begin
            status_reg <= offer_status;
            if (shift_prev) begin
                prev_time_reg <= cur_time_reg;
            end
            if (take_item) begin
                cur_gen_reg   <= in_gen_reg;
                cur_tick_reg  <= in_tick_reg;
                cur_time_reg  <= in_time_reg;
                cur_ivl_reg   <= in_ivl_reg;
                cur_focus_reg <= in_focus_reg;
                cur_seq_reg   <= in_seq_reg;
            end
        end
    end

    // ---------------- alpha: setup and restoring divider ----------------
    assign ge_gap  = e_reg >= {1'b0, gap_reg};
    assign rem_shl = {rem_reg, 1'b0};
    assign q_bit   = rem_shl >= {1'b0, gap_reg};
    assign rem_sub = rem_shl - {1'b0, gap_reg};

    assign stat.skip_div = !hist_ok_reg || le_reg || ge_gap;

    always_ff @(posedge aclk) begin
        if (cmd.calc_gap) begin
            gap_reg     <= cur_time_reg - prev_time_reg;
            base_reg    <= {1'b0, prev_time_reg} + {{(TIME_W + 1 - IVL_W){1'b0}}, cur_ivl_reg};
            hist_ok_reg <= have_prev_reg && have_cur_reg && (cur_time_reg > prev_time_reg);
        end
        if (cmd.calc_diff) begin
            e_reg  <= {1'b0, in_time_reg} - base_reg;
            le_reg <= {1'b0, in_time_reg} <= base_reg;
        end
        if (cmd.decide) begin
            rem_reg <= e_reg[TIME_W-1:0];
            if (!hist_ok_reg) begin
                alpha_reg <= Q16_ONE;
            end else if (le_reg) begin
                alpha_reg <= '0;
            end else if (ge_gap) begin
                alpha_reg <= Q16_ONE;
            end else begin
                alpha_reg <= '0;
            end
        end else if (cmd.div_step) begin
            // one quotient bit per cycle, MSB first
            rem_reg   <= q_bit ? rem_sub[TIME_W-1:0] : rem_shl[TIME_W-1:0];
            alpha_reg <= {1'b0, alpha_reg[ALPHA_W-3:0], q_bit};
        end
    end

    assign alpha_inv = Q16_ONE - alpha_reg;

    // ---------------- per-channel storage and blend ----------------
    for (genvar i = 0; i < int'(MAX_CHANNELS); i++) begin : g_chan
        if (i < int'(COLOR_CHANNELS)) begin : g_used
            logic [PROD_W+1:0] blend_sum;

            always_ff @(posedge aclk) begin
                if (cmd.load_input) begin
                    in_color_reg[i] <= in_colors[i];
                end
                if (cmd.offer_commit) begin
                    if (shift_prev) begin
                        prev_color_reg[i] <= cur_color_reg[i];
                    end
                    if (take_item) begin
                        cur_color_reg[i] <= in_color_reg[i];
                    end
                end
                if (cmd.mult) begin
                    prod_prev_reg[i] <= PROD_W'({{ALPHA_W{1'b0}}, prev_color_reg[i]}
                                                * {{COLOR_W{1'b0}}, alpha_inv});
                    prod_cur_reg[i]  <= PROD_W'({{ALPHA_W{1'b0}}, cur_color_reg[i]}
                                                * {{COLOR_W{1'b0}}, alpha_reg});
                end
            end

            assign blend_sum = {2'b00, prod_prev_reg[i]} + {2'b00, prod_cur_reg[i]}
                             + {{(PROD_W + 2 - ALPHA_W){1'b0}}, BLEND_ROUND};

            always_comb begin
                if (!frame_reg || !have_cur_reg) begin
                    out_color_next[i] = '0;
                end else if (have_prev_reg) begin
                    out_color_next[i] = blend_sum[COLOR_W +: COLOR_W];
                end else begin
                    out_color_next[i] = cur_color_reg[i];
                end
            end
        end else begin : g_unused
            assign out_color_next[i] = '0;
        end
    end

    // ---------------- input ordering ----------------
    assign pick_given = !have_cur_reg || in_focus_reg > cur_focus_reg
                     || (in_focus_reg == cur_focus_reg && in_seq_reg >= cur_seq_reg);

    always_comb begin
        if (!frame_reg) begin
            out_focus_next = '0;
            out_seq_next   = '0;
        end else if (pick_given) begin
            out_focus_next = in_focus_reg;
            out_seq_next   = in_seq_reg;
        end else begin
            out_focus_next = cur_focus_reg;
            out_seq_next   = cur_seq_reg;
        end
    end

    // ---------------- output register ----------------
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.finish_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish_load) begin
            out_status_reg <= frame_reg ? STATUS_FRAME : status_reg;
            out_snap_reg   <= have_cur_reg;
            out_alpha_reg  <= frame_reg ? alpha_reg : '0;
            out_color_reg  <= out_color_next;
            out_focus_reg  <= out_focus_next;
            out_seq_reg    <= out_seq_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = out_status_reg;
    assign m_snapshot_valid   = out_snap_reg;
    assign m_blend_factor     = out_alpha_reg;
    assign m_colors           = out_color_reg;
    assign m_focus_generation = out_focus_reg;
    assign m_input_sequence   = out_seq_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb_render_snapshot_interpolator.sv
// Self-checking testbench for render_snapshot_interpolator: directed, random, stall tests.
// Keeps its own snapshot store to predict every result and checks the results in order.
// Depends on rsi_pkg and the render_snapshot_interpolator RTL.
`timescale 1ns / 1ps

module tb_render_snapshot_interpolator;
    import rsi_pkg::*;

    localparam int unsigned CHANNELS     = 4;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 30;
    localparam int unsigned SHOWN_ERRORS = 10;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic                                 opcode;
        logic [GEN_W-1:0]                     generation;
        logic [TICK_W-1:0]                    tick;
        logic [TIME_W-1:0]                    stamp;
        logic [IVL_W-1:0]                     interval;
        logic [MAX_CHANNELS-1:0][COLOR_W-1:0] color;     // [0] red .. [3] alpha
        logic [ORDER_W-1:0]                   focus;
        logic [ORDER_W-1:0]                   seq_no;
    } snap_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]                  status;
        logic                                 snapshot_valid;
        logic [ALPHA_W-1:0]                   blend;
        logic [MAX_CHANNELS-1:0][COLOR_W-1:0] color;
        logic [ORDER_W-1:0]                   focus;
        logic [ORDER_W-1:0]                   seq_no;
    } frame_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_opcode = 1'b0;
    logic [GEN_W-1:0]    s_generation = '0;
    logic [TICK_W-1:0]   s_tick = '0;
    logic [TIME_W-1:0]   s_time_stamp = '0;
    logic [IVL_W-1:0]    s_fixed_interval = '0;
    logic [COLOR_W-1:0]  s_color_red = '0;
    logic [COLOR_W-1:0]  s_color_green = '0;
    logic [COLOR_W-1:0]  s_color_blue = '0;
    logic [COLOR_W-1:0]  s_color_alpha = '0;
    logic [ORDER_W-1:0]  s_focus_generation = '0;
    logic [ORDER_W-1:0]  s_input_sequence = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic                m_snapshot_valid;
    logic [ALPHA_W-1:0]  m_blend_factor;
    logic [COLOR_W-1:0]  m_out_red;
    logic [COLOR_W-1:0]  m_out_green;
    logic [COLOR_W-1:0]  m_out_blue;
    logic [COLOR_W-1:0]  m_out_alpha_channel;
    logic [ORDER_W-1:0]  m_out_focus_generation;
    logic [ORDER_W-1:0]  m_out_input_sequence;

    // Predicted snapshot store
    bit                 have_cur = 1'b0;
    bit                 have_prev = 1'b0;
    logic [GEN_W-1:0]   cur_gen = '0;
    logic [TICK_W-1:0]  cur_tick = '0;
    logic [TIME_W-1:0]  cur_stamp = '0;
    logic [IVL_W-1:0]   cur_ivl = '0;
    logic [COLOR_W-1:0] cur_color [CHANNELS] = '{default: '0};
    logic [ORDER_W-1:0] cur_focus = '0;
    logic [ORDER_W-1:0] cur_seq = '0;
    logic [TIME_W-1:0]  prev_stamp = '0;
    logic [COLOR_W-1:0] prev_color [CHANNELS] = '{default: '0};

    frame_result_t expected_results [$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   idle_pct = 0;
    int unsigned   stall_pct = 0;
    int unsigned   hold_request = 0;
    int unsigned   hold_left = 0;

    render_snapshot_interpolator #(
        .COLOR_CHANNELS(CHANNELS)
    ) dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_opcode              (s_opcode),
        .s_generation          (s_generation),
        .s_tick                (s_tick),
        .s_time_stamp          (s_time_stamp),
        .s_fixed_interval      (s_fixed_interval),
        .s_color_red           (s_color_red),
        .s_color_green         (s_color_green),
        .s_color_blue          (s_color_blue),
        .s_color_alpha         (s_color_alpha),
        .s_focus_generation    (s_focus_generation),
        .s_input_sequence      (s_input_sequence),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_status              (m_status),
        .m_snapshot_valid      (m_snapshot_valid),
        .m_blend_factor        (m_blend_factor),
        .m_out_red             (m_out_red),
        .m_out_green           (m_out_green),
        .m_out_blue            (m_out_blue),
        .m_out_alpha_channel   (m_out_alpha_channel),
        .m_out_focus_generation(m_out_focus_generation),
        .m_out_input_sequence  (m_out_input_sequence)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Q16 position of the frame time between previous and current snapshot
    function automatic logic [ALPHA_W-1:0] blend_weight(logic [TIME_W-1:0] now);
        logic [63:0] gap;
        logic [63:0] base;
        logic [63:0] ofs;
        logic [79:0] quot;
        if (!have_prev || !have_cur || cur_stamp <= prev_stamp) return Q16_ONE;
        gap  = 64'(cur_stamp) - 64'(prev_stamp);
        base = 64'(prev_stamp) + 64'(cur_ivl);
        if (64'(now) <= base) return '0;
        ofs = 64'(now) - base;
        if (ofs >= gap) return Q16_ONE;
        quot = {ofs, 16'h0000} / {16'h0000, gap};
        return quot[ALPHA_W-1:0];
    endfunction

    function automatic void load_current(snap_item_t it);
        int ch;
        cur_gen   = it.generation;
        cur_tick  = it.tick;
        cur_stamp = it.stamp;
        cur_ivl   = it.interval;
        for (ch = 0; ch < CHANNELS; ch++) cur_color[ch] = it.color[ch];
        cur_focus = it.focus;
        cur_seq   = it.seq_no;
        have_cur  = 1'b1;
    endfunction

    // Apply one item to the predicted store and return the result it causes
    function automatic frame_result_t track_snapshot(snap_item_t it);
        frame_result_t      res;
        logic [ALPHA_W-1:0] a;
        logic [63:0]        mix;
        int                 ch;
        res = '0;
        if (it.opcode == OP_OFFER) begin
            if (it.interval == '0) begin
                res.status = STATUS_REJECTED;
            end else if (!have_cur || it.generation > cur_gen) begin
                have_prev = 1'b0;
                load_current(it);
                res.status = STATUS_NEW_GEN;
            end else if (it.generation < cur_gen || it.tick <= cur_tick) begin
                res.status = STATUS_STALE;
            end else begin
                if (it.stamp <= cur_stamp || it.interval != cur_ivl) begin
                    have_prev = 1'b0;
                    res.status = STATUS_HIST_RST;
                end else begin
                    prev_stamp = cur_stamp;
                    prev_color = cur_color;
                    have_prev  = 1'b1;
                    res.status = STATUS_ADVANCED;
                end
                load_current(it);
            end
            res.snapshot_valid = have_cur;
            return res;
        end

        a = blend_weight(it.stamp);
        res.status         = STATUS_FRAME;
        res.snapshot_valid = have_cur;
        res.blend          = a;
        for (ch = 0; ch < CHANNELS; ch++) begin
            if (have_cur && have_prev) begin
                mix = 64'(prev_color[ch]) * (64'(Q16_ONE) - 64'(a))
                    + 64'(cur_color[ch]) * 64'(a) + 64'(BLEND_ROUND);
                res.color[ch] = mix[31:16];
            end else if (have_cur) begin
                res.color[ch] = cur_color[ch];
            end
        end
        if (!have_cur || it.focus > cur_focus
                || (it.focus == cur_focus && it.seq_no >= cur_seq)) begin
            res.focus  = it.focus;
            res.seq_no = it.seq_no;
        end else begin
            res.focus  = cur_focus;
            res.seq_no = cur_seq;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [COLOR_W-1:0] rand_color();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return COLOR_W'($urandom());
    endfunction

    function automatic logic [IVL_W-1:0] rand_interval();
        int unsigned      pick;
        logic [IVL_W-1:0] v;
        pick = $urandom_range(0, 9);
        if (pick < 6) return $urandom_range(1, 1000);
        if (pick < 9) return $urandom_range(1000, 20_000_000);
        v = $urandom();
        return (v == '0) ? IVL_W'(1) : v;
    endfunction

    function automatic snap_item_t offer_item(
        logic [GEN_W-1:0] gen, logic [TICK_W-1:0] tick, logic [TIME_W-1:0] stamp,
        logic [IVL_W-1:0] ivl, logic [COLOR_W-1:0] red, logic [COLOR_W-1:0] green,
        logic [COLOR_W-1:0] blue, logic [COLOR_W-1:0] alpha,
        logic [ORDER_W-1:0] focus, logic [ORDER_W-1:0] seq_no);
        snap_item_t it;
        it.opcode     = OP_OFFER;
        it.generation = gen;
        it.tick       = tick;
        it.stamp      = stamp;
        it.interval   = ivl;
        it.color[0]   = red;
        it.color[1]   = green;
        it.color[2]   = blue;
        it.color[3]   = alpha;
        it.focus      = focus;
        it.seq_no     = seq_no;
        return it;
    endfunction

    // Prepare item; the fields it does not use carry random noise
    function automatic snap_item_t frame_item(
        logic [TIME_W-1:0] now, logic [ORDER_W-1:0] focus, logic [ORDER_W-1:0] seq_no);
        snap_item_t it;
        it = offer_item($urandom(), $urandom(), '0, $urandom(),
                        COLOR_W'($urandom()), COLOR_W'($urandom()),
                        COLOR_W'($urandom()), COLOR_W'($urandom()), focus, seq_no);
        it.opcode = OP_FRAME;
        it.stamp  = now;
        return it;
    endfunction

    // Mostly a well-formed timeline built on the predicted store, some noise
    function automatic snap_item_t next_random_item();
        snap_item_t         it;
        logic [63:0]        v;
        logic [63:0]        gap;
        logic [63:0]        base;
        logic [63:0]        lo;
        logic [ORDER_W-1:0] f;
        logic [ORDER_W-1:0] q;
        int unsigned        pick;
        pick = $urandom_range(0, 99);
        v = 64'(cur_stamp) + 64'(cur_ivl);
        if ($urandom_range(0, 4) == 0) v += 64'($urandom_range(1, cur_ivl));
        it = offer_item(cur_gen, cur_tick + $urandom_range(1, 3), v[TIME_W-1:0], cur_ivl,
                        rand_color(), rand_color(), rand_color(), rand_color(),
                        cur_focus + $urandom_range(0, 1), cur_seq + $urandom_range(0, 5));

        if (pick >= 92) begin
            v = rand64();
            it = offer_item($urandom(), $urandom(), v[TIME_W-1:0], $urandom(),
                            COLOR_W'($urandom()), COLOR_W'($urandom()),
                            COLOR_W'($urandom()), COLOR_W'($urandom()),
                            $urandom(), $urandom());
            it.opcode = 1'($urandom_range(0, 1));
        end else if (pick >= 40 && pick < 70) begin
            if (have_prev) begin
                gap  = 64'(cur_stamp) - 64'(prev_stamp);
                base = 64'(prev_stamp) + 64'(cur_ivl);
                lo   = (base > gap / 4) ? base - gap / 4 : '0;
                v    = lo + rand64() % (gap + gap / 2 + 1);
            end else begin
                v = 64'(cur_stamp) + 64'($urandom_range(0, 1000));
            end
            if ($urandom_range(0, 9) == 0) v = rand64();
            if (v[63]) v = 64'(TIME_MAX);
            case ($urandom_range(0, 4))
                0, 1: begin
                    f = cur_focus;
                    q = cur_seq + $urandom_range(0, 2) - 1;
                end
                2: begin
                    f = cur_focus + 1;
                    q = $urandom();
                end
                3: begin
                    f = cur_focus - 1;
                    q = $urandom();
                end
                default: begin
                    f = $urandom();
                    q = $urandom();
                end
            endcase
            it = frame_item(v[TIME_W-1:0], f, q);
        end else if (!have_cur || v[63] || (pick >= 70 && pick < 78)) begin
            // start a fresh timeline
            it.generation = cur_gen + $urandom_range(1, 3);
            it.tick       = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 100);
            v             = rand64();
            it.stamp      = v[TIME_W-1:0] >> $urandom_range(2, 40);
            it.interval   = rand_interval();
        end else if (pick >= 78 && pick < 81) begin
            it.generation = cur_gen - 1;
        end else if (pick >= 81 && pick < 84) begin
            it.tick = cur_tick - $urandom_range(0, 2);
        end else if (pick >= 84 && pick < 88) begin
            it.interval = '0;
        end else if (pick >= 88) begin
            if ($urandom_range(0, 1) == 0) it.interval = cur_ivl + $urandom_range(1, 50);
            else it.stamp = cur_stamp - TIME_W'($urandom_range(0, 3));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    // Called at a rising edge; returns at the edge that accepts the item
    task automatic send_item(snap_item_t it);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_opcode           <= it.opcode;
        s_generation       <= it.generation;
        s_tick             <= it.tick;
        s_time_stamp       <= it.stamp;
        s_fixed_interval   <= it.interval;
        s_color_red        <= it.color[0];
        s_color_green      <= it.color[1];
        s_color_blue       <= it.color[2];
        s_color_alpha      <= it.color[3];
        s_focus_generation <= it.focus;
        s_input_sequence   <= it.seq_no;
        do @(negedge aclk); while (!s_ready);
        expected_results.push_back(track_snapshot(it));
        @(posedge aclk);
    endtask

    function automatic string describe(frame_result_t r);
        return $sformatf("status=%0d valid=%0d blend=%h rgba=%h/%h/%h/%h focus=%h seq=%h",
                         r.status, r.snapshot_valid, r.blend, r.color[0], r.color[1],
                         r.color[2], r.color[3], r.focus, r.seq_no);
    endfunction

    // Sample at the falling edge: the item moves at the next rising edge
    always @(negedge aclk) begin
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.status         = m_status;
            got.snapshot_valid = m_snapshot_valid;
            got.blend          = m_blend_factor;
            got.color[0]       = m_out_red;
            got.color[1]       = m_out_green;
            got.color[2]       = m_out_blue;
            got.color[3]       = m_out_alpha_channel;
            got.focus          = m_out_focus_generation;
            got.seq_no         = m_out_input_sequence;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_ERRORS)
                    $display("unexpected result: %s", describe(got));
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_frame_without_history();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(frame_item('0, '0, '0));
        send_item(frame_item(TIME_MAX, '1, '1));
        send_item(offer_item(7, 1, 500, '0, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 1, 1));
    endtask

    task automatic test_timeline_updates();
        send_item(offer_item(5, 10, 1000, 100, 16'h0000, 16'hFFFF, 16'h1234, 16'h8000, 3, 7));
        send_item(offer_item(5, 11, 1100, 100, 16'hFFFF, 16'h0000, 16'h4321, 16'h0000, 3, 9));
        // lower generation, then same tick
        send_item(offer_item(4, 20, 5000, 100, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 9, 9));
        send_item(offer_item(5, 11, 5000, 100, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 9, 9));
    endtask

    task automatic test_frame_blend();
        send_item(frame_item(1100, 3, 6));         // at the base: previous colors
        send_item(frame_item(1150, 4, 0));         // halfway
        send_item(frame_item(1133, 3, 9));         // inexact quotient, equal ordering
        send_item(frame_item(1200, 2, '1));        // at the end of the gap
        send_item(frame_item(1250, 3, 10));        // beyond the gap
    endtask

    task automatic test_history_breaks();
        send_item(offer_item(5, 12, 1100, 100, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 3, 10));
        send_item(frame_item(1150, 3, 10));
        send_item(offer_item(5, 13, 1200, 100, 16'h1000, 16'h2000, 16'h3000, 16'h4000, 3, 11));
        send_item(offer_item(5, 14, 1300, 200, 16'hAAAA, 16'hBBBB, 16'hCCCC, 16'hDDDD, 3, 12));
        send_item(offer_item(5, 15, 1400, '0, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 3, 13));
        send_item(frame_item(1450, 3, 12));
    endtask

    task automatic test_random(int unsigned count, int unsigned sender_idle,
                               int unsigned receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (count) send_item(next_random_item());
    endtask

    // Hold the receiver off while items keep coming, so the input stalls
    task automatic test_backpressure();
        idle_pct     = 0;
        stall_pct    = 0;
        hold_request = 300;
        repeat (30) send_item(next_random_item());
    endtask

    task automatic test_field_extremes();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(offer_item('1, '0, '0, '1, '1, '1, '1, '1, '1, '1));
        send_item(offer_item('1, '1, TIME_MAX, '1, '0, '0, '0, '0, '0, '0));
        send_item(frame_item(TIME_MAX, '1, '0));
        send_item(frame_item(63'h4000_0000_0000_0000, '0, '1));
        send_item(frame_item('0, '0, '0));
        send_item(offer_item('0, '1, TIME_MAX, '1, '1, '1, '1, '1, '1, '1));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_frame_without_history();
        test_timeline_updates();
        test_frame_blend();
        test_history_breaks();
        test_random(450, 0, 0);
        test_random(350, 84, 0);
        test_random(350, 0, 84);
        test_random(350, 15, 15);
        test_backpressure();
        test_field_extremes();
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rsi_pkg.sv
rtl/core/rsi_ctrl.sv
rtl/core/rsi_datapath.sv
rtl/core/render_snapshot_interpolator.sv
tb/sv/tb_render_snapshot_interpolator.sv
